@@ hdl/att_pkg.sv @@
// ----------------------------------------------------------------------------
// att_pkg
// Shared types and constants of the alarm time table: table size, field
// widths, function codes, the stored entry and the sequencer states.
// ----------------------------------------------------------------------------
package att_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);

	localparam int FUNC_W  = 3;
	localparam int TIME_W  = 12;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int FIELD_W = 4;

	localparam int HOUR_SCALE   = 100;
	localparam int HOUR_LIMIT   = 24;
	localparam int MINUTE_LIMIT = 60;

	typedef enum logic [FUNC_W-1:0] {
		FN_TICK  = 3'd0,
		FN_DOWN  = 3'd1,
		FN_UP    = 3'd2,
		FN_ADD   = 3'd3,
		FN_DEL   = 3'd4,
		FN_CLEAR = 3'd5
	} func_t;

	typedef struct packed {
		logic              fired;
		logic [TIME_W-1:0] hhmm;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

endpackage

@@ hdl/att_in_if.sv @@
// ----------------------------------------------------------------------------
// att_in_if
// Request channel of the alarm time table: valid/ready and the item fields.
// ----------------------------------------------------------------------------
interface att_in_if import att_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [TIME_W-1:0] now_hhmm;
	logic [HOUR_W-1:0] add_hour;
	logic [MIN_W-1:0]  add_minute;

	modport source (output valid, func, now_hhmm, add_hour, add_minute, input ready);
	modport sink   (input valid, func, now_hhmm, add_hour, add_minute, output ready);

endinterface

@@ hdl/att_out_if.sv @@
// ----------------------------------------------------------------------------
// att_out_if
// Result channel of the alarm time table: valid/ready and the result fields.
// ----------------------------------------------------------------------------
interface att_out_if import att_pkg::*; ();

	logic               valid;
	logic               ready;
	logic               fired;
	logic [FIELD_W-1:0] fired_slot;
	logic               accepted;
	logic [FIELD_W-1:0] entry_count;
	logic [FIELD_W-1:0] cursor;

	modport source (output valid, fired, fired_slot, accepted, entry_count, cursor,
		input ready);
	modport sink   (input valid, fired, fired_slot, accepted, entry_count, cursor,
		output ready);

endinterface

@@ hdl/att_ram.sv @@
// ----------------------------------------------------------------------------
// att_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. No reset on the contents.
// ----------------------------------------------------------------------------
module att_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/alarm_time_table.sv @@
// ----------------------------------------------------------------------------
// alarm_time_table
// Ordered list of alarm times with fired marks, a live count and a cursor.
// ----------------------------------------------------------------------------
// Each request beat carries one function: tick, cursor down, cursor up, add,
// delete or clear fired marks, and produces exactly one result beat. Times
// and fired marks live in one table RAM; count and cursor live in flops. A
// sequencer streams through the table one entry per cycle (read, then
// modify and write back the next cycle). An item touches n entries:
// live_count for tick and clear, live_count-cursor for add,
// live_count-cursor-1 for delete, 0 otherwise. The sequencer streams those n
// entries, then loads the result in ST_DONE and returns to ST_IDLE, ready for
// the next request, so a new request is only taken once the previous item
// has left the sequencer. n is at most TABLE_DEPTH-1. A new request is taken
// while the previous result still waits in the output register; its result
// is held back until that register is free, and the input stalls meanwhile.
// Entries outside the live range are never read, so the table needs no
// clearing after reset.
// ----------------------------------------------------------------------------
module alarm_time_table import att_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	att_in_if.sink    req,
	att_out_if.source rsp
);

	state_t state_q, state_nx;

	// count and cursor, always kept clamped
	logic [IDX_W-1:0] cnt_q, cur_q;

	// per-item context
	func_t             op_q;
	logic [TIME_W-1:0] now_q, new_time_q;
	logic [IDX_W-1:0]  sel_q, rd_q, n_q, slot_q;
	logic              acc_q, fired_q;

	// read stage
	logic              v_s1;
	logic [IDX_W-1:0]  addr_s1, waddr_s1;

	// output register
	logic               out_v_q;
	logic               out_fired_q, out_acc_q;
	logic [FIELD_W-1:0] out_slot_q, out_cnt_q, out_cur_q;

	// ram port
	logic              ram_we, ram_re;
	logic [IDX_W-1:0]  ram_waddr, ram_raddr;
	entry_t            ram_wdata, ram_rdata;
	logic [ENTRY_W-1:0] ram_rdata_raw;

	logic accept, load_out, tick_hit, stream_done;

	// plan of an incoming item
	logic              add_ok;
	logic              plan_acc;
	logic [IDX_W-1:0]  plan_cnt, plan_cur, plan_n, plan_rd;
	logic [TIME_W-1:0] plan_time;

	att_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata_raw)
	);

	assign ram_rdata = entry_t'(ram_rdata_raw);

	assign accept      = req.valid && req.ready;
	assign stream_done = (n_q == '0) && !v_s1;
	assign tick_hit    = v_s1 && (op_q == FN_TICK) && !ram_rdata.fired
		&& (ram_rdata.hhmm == now_q);

	always_comb begin
		add_ok = (cnt_q < IDX_W'(TABLE_DEPTH - 1))
			&& (req.add_hour < HOUR_W'(HOUR_LIMIT))
			&& (req.add_minute < MIN_W'(MINUTE_LIMIT));
		plan_time = TIME_W'(req.add_hour) * TIME_W'(HOUR_SCALE) + TIME_W'(req.add_minute);
		plan_acc = 1'b0;
		plan_cnt = cnt_q;
		plan_cur = cur_q;
		plan_n   = '0;
		plan_rd  = '0;
		unique case (req.func) inside
			FN_TICK, FN_CLEAR: begin
				plan_n = cnt_q;
			end
			FN_DOWN: begin
				if (cnt_q != '0) begin
					plan_cur = (cur_q + 1'b1 == cnt_q) ? '0 : cur_q + 1'b1;
				end
			end
			FN_UP: begin
				if (cnt_q != '0) begin
					plan_cur = (cur_q == '0) ? cnt_q - 1'b1 : cur_q - 1'b1;
				end
			end
			FN_ADD: begin
				if (add_ok) begin
					plan_acc = 1'b1;
					plan_cnt = cnt_q + 1'b1;
					plan_n   = cnt_q - cur_q;
					plan_rd  = cnt_q - 1'b1;
				end
			end
			FN_DEL: begin
				if (cnt_q != '0) begin
					plan_acc = 1'b1;
					plan_cnt = cnt_q - 1'b1;
					plan_n   = cnt_q - 1'b1 - cur_q;
					plan_rd  = cur_q + 1'b1;
					if (cnt_q == IDX_W'(1)) begin
						plan_cur = '0;
					end else if (cur_q >= cnt_q - 1'b1) begin
						plan_cur = cnt_q - IDX_W'(2);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_nx = ST_RUN;
			ST_RUN:  if (stream_done) state_nx = ST_DONE;
			ST_DONE: if (!out_v_q || rsp.ready) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready = 1'b0;
		load_out  = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = rd_q;
		ram_we    = 1'b0;
		ram_waddr = waddr_s1;
		ram_wdata = ram_rdata;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
			end
			ST_RUN: begin
				ram_re = (n_q != '0);
				if (v_s1) begin
					case (op_q) inside
						FN_TICK: begin
							ram_we          = tick_hit;
							ram_wdata.fired = 1'b1;
						end
						FN_CLEAR: begin
							ram_we          = 1'b1;
							ram_wdata.fired = 1'b0;
						end
						FN_ADD, FN_DEL: begin
							ram_we = 1'b1;
						end
						default: begin
						end
					endcase
				end else if (stream_done && (op_q == FN_ADD) && acc_q) begin
					// new entry goes in at the cursor once the shift is done
					ram_we          = 1'b1;
					ram_waddr       = sel_q;
					ram_wdata.fired = 1'b0;
					ram_wdata.hhmm  = new_time_q;
				end
			end
			ST_DONE: begin
				load_out = !out_v_q || rsp.ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			cur_q   <= '0;
			n_q     <= '0;
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			v_s1    <= ram_re;
			if (accept) begin
				cnt_q <= plan_cnt;
				cur_q <= plan_cur;
				n_q   <= plan_n;
			end else if (ram_re) begin
				n_q <= n_q - 1'b1;
			end
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= func_t'(req.func);
			now_q      <= req.now_hhmm;
			new_time_q <= plan_time;
			sel_q      <= cur_q;
			rd_q       <= plan_rd;
			acc_q      <= plan_acc;
			fired_q    <= 1'b0;
			slot_q     <= '0;
		end else begin
			if (ram_re) begin
				rd_q    <= (op_q == FN_ADD) ? rd_q - 1'b1 : rd_q + 1'b1;
				addr_s1 <= rd_q;
				// add shifts entries up, delete shifts them down
				case (op_q)
					FN_ADD:  waddr_s1 <= rd_q + 1'b1;
					FN_DEL:  waddr_s1 <= rd_q - 1'b1;
					default: waddr_s1 <= rd_q;
				endcase
			end
			if (tick_hit && !fired_q) begin
				fired_q <= 1'b1;
				slot_q  <= addr_s1;
			end
		end
		if (load_out) begin
			out_fired_q <= fired_q;
			out_slot_q  <= FIELD_W'(slot_q);
			out_acc_q   <= acc_q;
			out_cnt_q   <= FIELD_W'(cnt_q);
			out_cur_q   <= FIELD_W'(cur_q);
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.fired       = out_fired_q;
	assign rsp.fired_slot  = out_slot_q;
	assign rsp.accepted    = out_acc_q;
	assign rsp.entry_count = out_cnt_q;
	assign rsp.cursor      = out_cur_q;

	// cursor stays inside the live range
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 && cur_q == '0) || (cur_q < cnt_q))
		else $error("cursor outside live range");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= IDX_W'(TABLE_DEPTH - 1))
		else $error("live count beyond table limit");

	// streaming never writes the entry being read in the same cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("table read and write hit the same entry");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> (!v_s1 && !ram_we))
		else $error("request taken while table access pending");

endmodule

@@ dv/tb_alarm_time_table.sv @@
// ----------------------------------------------------------------------------
// tb_alarm_time_table
// Self-checking testbench for the alarm time table.
// ----------------------------------------------------------------------------
// A short scripted sequence comes first. It covers the empty list, refused
// adds, the latest and earliest times, repeated and multiple matches, the
// unused function codes and cursor wrap and clamp. Random traffic follows in
// add-heavy and delete-heavy stretches, so the list both fills up and empties
// out. Tick times are mostly drawn from the stored alarms so that ticks fire.
// Every accepted request is run through a local model of the table. Each
// result beat is compared with the oldest expected result. Sender and
// receiver idle in three mixes. In one stretch the receiver holds off for a
// long time while the sender keeps offering requests.
// ----------------------------------------------------------------------------
module tb_alarm_time_table import att_pkg::*; ();

	localparam logic [FUNC_W-1:0] FN_SPARE6 = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE7 = 3'd7;

	localparam int SCRIPT_LEN   = 25;
	localparam int PHASE_ITEMS  = 550;
	localparam int SEGMENT_LEN  = 60;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [TIME_W-1:0] now_hhmm;
		logic [HOUR_W-1:0] add_hour;
		logic [MIN_W-1:0]  add_minute;
	} alarm_req_t;

	typedef struct packed {
		logic               fired;
		logic [FIELD_W-1:0] fired_slot;
		logic               accepted;
		logic [FIELD_W-1:0] entry_count;
		logic [FIELD_W-1:0] cursor;
	} alarm_rsp_t;

	typedef struct packed {
		alarm_req_t req;
		logic       typed;
		alarm_rsp_t rsp;
	} script_row_t;

	logic clk;
	logic arst_n;

	att_in_if  req_if ();
	att_out_if rsp_if ();

	alarm_time_table DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// local copy of the table
	logic [TIME_W-1:0] model_times [TABLE_DEPTH];
	logic              model_marks [TABLE_DEPTH];
	int                model_count;
	int                model_cursor;

	alarm_rsp_t expected_q [$];
	alarm_rsp_t got_rsp;
	alarm_rsp_t want_rsp;

	int send_idle_pct;
	int recv_idle_pct;
	int hold_req;
	int errors;
	int items_sent;
	int results_seen;
	int fired_ticks;
	int refused_adds;
	int full_refusals;
	int stall_cycles;

	// the latest time, refused adds, the empty list and the unused codes are typed in
	script_row_t script [SCRIPT_LEN] = '{
		'{'{FN_TICK,   12'd0,    5'd0,  6'd0},  1'b1, '{1'b0, 4'd0, 1'b0, 4'd0, 4'd0}},
		'{'{FN_DOWN,   12'd0,    5'd0,  6'd0},  1'b1, '{1'b0, 4'd0, 1'b0, 4'd0, 4'd0}},
		'{'{FN_UP,     12'd0,    5'd0,  6'd0},  1'b1, '{1'b0, 4'd0, 1'b0, 4'd0, 4'd0}},
		'{'{FN_DEL,    12'd0,    5'd0,  6'd0},  1'b1, '{1'b0, 4'd0, 1'b0, 4'd0, 4'd0}},
		'{'{FN_ADD,    12'd0,    5'd24, 6'd0},  1'b1, '{1'b0, 4'd0, 1'b0, 4'd0, 4'd0}},
		'{'{FN_ADD,    12'd0,    5'd23, 6'd60}, 1'b1, '{1'b0, 4'd0, 1'b0, 4'd0, 4'd0}},
		'{'{FN_ADD,    12'd4095, 5'd31, 6'd63}, 1'b1, '{1'b0, 4'd0, 1'b0, 4'd0, 4'd0}},
		'{'{FN_ADD,    12'd0,    5'd23, 6'd59}, 1'b1, '{1'b0, 4'd0, 1'b1, 4'd1, 4'd0}},
		'{'{FN_ADD,    12'd0,    5'd0,  6'd0},  1'b0, '0},
		'{'{FN_TICK,   12'd2359, 5'd0,  6'd0},  1'b1, '{1'b1, 4'd1, 1'b0, 4'd2, 4'd0}},
		'{'{FN_TICK,   12'd2359, 5'd0,  6'd0},  1'b0, '0},
		'{'{FN_CLEAR,  12'd0,    5'd0,  6'd0},  1'b0, '0},
		'{'{FN_TICK,   12'd0,    5'd0,  6'd0},  1'b0, '0},
		'{'{FN_DOWN,   12'd0,    5'd0,  6'd0},  1'b0, '0},
		'{'{FN_DOWN,   12'd0,    5'd0,  6'd0},  1'b0, '0},
		'{'{FN_UP,     12'd0,    5'd0,  6'd0},  1'b0, '0},
		'{'{FN_ADD,    12'd0,    5'd12, 6'd30}, 1'b0, '0},
		'{'{FN_ADD,    12'd0,    5'd12, 6'd30}, 1'b0, '0},
		'{'{FN_TICK,   12'd1230, 5'd0,  6'd0},  1'b0, '0},
		'{'{FN_TICK,   12'd4095, 5'd0,  6'd0},  1'b1, '{1'b0, 4'd0, 1'b0, 4'd4, 4'd1}},
		'{'{FN_SPARE6, 12'd0,    5'd0,  6'd0},  1'b1, '{1'b0, 4'd0, 1'b0, 4'd4, 4'd1}},
		'{'{FN_SPARE7, 12'd4095, 5'd31, 6'd63}, 1'b1, '{1'b0, 4'd0, 1'b0, 4'd4, 4'd1}},
		'{'{FN_DEL,    12'd0,    5'd0,  6'd0},  1'b0, '0},
		'{'{FN_DOWN,   12'd0,    5'd0,  6'd0},  1'b0, '0},
		'{'{FN_DEL,    12'd0,    5'd0,  6'd0},  1'b0, '0}
	};

	initial begin
		clk = 1'b0;
	end

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void clamp_model_cursor();
		if (model_count == 0) begin
			model_cursor = 0;
		end else if (model_cursor > model_count - 1) begin
			model_cursor = model_count - 1;
		end
	endfunction

	function automatic alarm_rsp_t predict_alarm(alarm_req_t it);
		alarm_rsp_t r;
		r = '0;
		clamp_model_cursor();
		case (it.func)
			FN_TICK: begin
				for (int k = 0; k < model_count; k++) begin
					if (!model_marks[k] && model_times[k] == it.now_hhmm) begin
						model_marks[k] = 1'b1;
						if (!r.fired) begin
							r.fired      = 1'b1;
							r.fired_slot = FIELD_W'(k);
						end
					end
				end
				if (r.fired) begin
					fired_ticks++;
				end
			end
			FN_DOWN: begin
				if (model_count != 0) begin
					model_cursor = (model_cursor + 1) % model_count;
				end
			end
			FN_UP: begin
				if (model_count != 0) begin
					model_cursor = (model_cursor + model_count - 1) % model_count;
				end
			end
			FN_ADD: begin
				if (model_count < TABLE_DEPTH - 1 && it.add_hour < HOUR_LIMIT &&
						it.add_minute < MINUTE_LIMIT) begin
					for (int k = model_count; k > model_cursor; k--) begin
						model_times[k] = model_times[k-1];
						model_marks[k] = model_marks[k-1];
					end
					model_times[model_cursor] = TIME_W'(it.add_hour * HOUR_SCALE + it.add_minute);
					model_marks[model_cursor] = 1'b0;
					model_count++;
					r.accepted = 1'b1;
				end else begin
					refused_adds++;
					if (model_count == TABLE_DEPTH - 1) begin
						full_refusals++;
					end
				end
			end
			FN_DEL: begin
				if (model_count != 0) begin
					for (int k = model_cursor; k + 1 < model_count; k++) begin
						model_times[k] = model_times[k+1];
						model_marks[k] = model_marks[k+1];
					end
					model_times[model_count-1] = '0;
					model_marks[model_count-1] = 1'b0;
					model_count--;
					r.accepted = 1'b1;
				end
			end
			FN_CLEAR: begin
				for (int k = 0; k < TABLE_DEPTH; k++) begin
					model_marks[k] = 1'b0;
				end
			end
			default: begin
			end
		endcase
		clamp_model_cursor();
		r.entry_count = FIELD_W'(model_count);
		r.cursor      = FIELD_W'(model_cursor);
		return r;
	endfunction

	// weights bias the list toward filling up or draining
	function automatic alarm_req_t random_request(int add_w, int del_w);
		alarm_req_t it;
		int         roll;
		it.func       = FN_TICK;
		it.now_hhmm   = TIME_W'($urandom_range(4095));
		it.add_hour   = HOUR_W'($urandom_range(31));
		it.add_minute = MIN_W'($urandom_range(63));
		roll = $urandom_range(30 + 20 + add_w + del_w + 4 + 2 - 1);
		if (roll < 30) begin
			it.func = FN_TICK;
			roll = $urandom_range(99);
			if (model_count > 0 && roll < 70) begin
				it.now_hhmm = model_times[$urandom_range(model_count - 1)];
			end else if (roll < 90) begin
				it.now_hhmm = TIME_W'($urandom_range(2359));
			end
		end else if (roll < 40) begin
			it.func = FN_DOWN;
		end else if (roll < 50) begin
			it.func = FN_UP;
		end else if (roll < 50 + add_w) begin
			it.func = FN_ADD;
			if ($urandom_range(99) < 85) begin
				it.add_hour   = HOUR_W'($urandom_range(HOUR_LIMIT - 1));
				it.add_minute = MIN_W'($urandom_range(MINUTE_LIMIT - 1));
			end
		end else if (roll < 50 + add_w + del_w) begin
			it.func = FN_DEL;
		end else if (roll < 54 + add_w + del_w) begin
			it.func = FN_CLEAR;
		end else begin
			it.func = $urandom_range(1) ? FN_SPARE6 : FN_SPARE7;
		end
		return it;
	endfunction

	// entered at a falling edge, returns at the falling edge after the beat
	task automatic drive_request(alarm_req_t it, logic typed, alarm_rsp_t typed_rsp);
		alarm_rsp_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid = 1'b0;
			@(negedge clk);
		end
		req_if.valid      = 1'b1;
		req_if.func       = it.func;
		req_if.now_hhmm   = it.now_hhmm;
		req_if.add_hour   = it.add_hour;
		req_if.add_minute = it.add_minute;
		@(posedge clk);
		while (!req_if.ready) begin
			@(posedge clk);
		end
		predicted = predict_alarm(it);
		expected_q.push_back(typed ? typed_rsp : predicted);
		items_sent++;
		@(negedge clk);
	endtask

	// receiver: random back-pressure plus an occasional long hold-off
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready = 1'b0;
			end else begin
				rsp_if.ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got_rsp = '{rsp_if.fired, rsp_if.fired_slot, rsp_if.accepted,
				rsp_if.entry_count, rsp_if.cursor};
			results_seen++;
			if (expected_q.size() == 0) begin
				$display("%0t unexpected result beat: fired=%0d slot=%0d acc=%0d count=%0d cur=%0d",
					$time, got_rsp.fired, got_rsp.fired_slot, got_rsp.accepted,
					got_rsp.entry_count, got_rsp.cursor);
				errors++;
			end else begin
				want_rsp = expected_q.pop_front();
				if (got_rsp !== want_rsp) begin
					$display("%0t mismatch: expected fired=%0d slot=%0d acc=%0d count=%0d cur=%0d",
						$time, want_rsp.fired, want_rsp.fired_slot, want_rsp.accepted,
						want_rsp.entry_count, want_rsp.cursor);
					$display("%0t            actual fired=%0d slot=%0d acc=%0d count=%0d cur=%0d",
						$time, got_rsp.fired, got_rsp.fired_slot, got_rsp.accepted,
						got_rsp.entry_count, got_rsp.cursor);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t watchdog: no beat for %0d cycles", $time, STALL_LIMIT);
			$display("FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int         send_mix [3];
		int         recv_mix [3];
		alarm_req_t it;
		send_mix = '{30, 85, 0};
		recv_mix = '{85, 30, 0};

		arst_n            = 1'b0;
		req_if.valid      = 1'b0;
		req_if.func       = FN_TICK;
		req_if.now_hhmm   = '0;
		req_if.add_hour   = '0;
		req_if.add_minute = '0;
		send_idle_pct     = send_mix[0];
		recv_idle_pct     = recv_mix[0];
		hold_req          = 0;
		items_sent        = 0;
		fired_ticks       = 0;
		refused_adds      = 0;
		full_refusals     = 0;
		model_count       = 0;
		model_cursor      = 0;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			model_times[k] = '0;
			model_marks[k] = 1'b0;
		end

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < SCRIPT_LEN; i++) begin
			drive_request(script[i].req, script[i].typed, script[i].rsp);
		end

		for (int p = 0; p < 3; p++) begin
			send_idle_pct = send_mix[p];
			recv_idle_pct = recv_mix[p];
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 2 && i == 100) begin
					hold_req++;
				end
				if ((i / SEGMENT_LEN) % 2 == 0) begin
					it = random_request(35, 8);
				end else begin
					it = random_request(8, 30);
				end
				drive_request(it, 1'b0, '0);
			end
		end
		req_if.valid = 1'b0;

		while (expected_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests and %0d results: %0d firing ticks, %0d refused adds",
			items_sent, results_seen, fired_ticks, refused_adds);
		$display("%0d adds refused on a full list; idle mixes 30/85, 85/30, none; one %0d-cycle hold",
			full_refusals, HOLD_CYCLES);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
